// ===== hw/rtl/snd_pkg.sv =====
package snd_pkg;

    localparam int PERM_SIZE       = 256;
    localparam int IDX_W           = $clog2(PERM_SIZE);
    localparam int COORD_FRAC_BITS = 16;
    localparam int SKEW_SH         = 32 - COORD_FRAC_BITS;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_EVAL2 = 2'd1;
    localparam logic [1:0] CMD_EVAL3 = 2'd2;

    // skew and unskew factors, unsigned q32
    localparam logic [31:0] F2_Q32 = 32'd1572067139;
    localparam logic [31:0] F3_Q32 = 32'd1431655765;
    localparam logic [31:0] G2_Q32 = 32'd907633386;
    localparam logic [31:0] G3_Q32 = 32'd715827883;

    // corner offsets, q28
    localparam logic signed [31:0] Q28_ONE  = 32'sd268435456;
    localparam logic signed [31:0] G2_Q28   = 32'sd56727087;
    localparam logic signed [31:0] G2X2_Q28 = 32'sd113454173;
    localparam logic signed [31:0] G3_Q28   = 32'sd44739243;
    localparam logic signed [31:0] G3X2_Q28 = 32'sd89478485;
    localparam logic signed [31:0] G3X3_Q28 = 32'sd134217728;

    // falloff radius, q56
    localparam logic signed [63:0] LIM2_Q56 = 64'sd36028797018963968;
    localparam logic signed [63:0] LIM3_Q56 = 64'sd43234556422756762;

    localparam logic signed [47:0] OUT_ONE = 48'sd1073741824;

endpackage

// ===== hw/rtl/snd_sample_if.sv =====
interface snd_sample_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [7:0]         perm_index;
    logic [7:0]         perm_value;
    logic signed [47:0] coord_x;
    logic signed [47:0] coord_y;
    logic signed [47:0] coord_z;

    modport source (output valid, cmd, perm_index, perm_value, coord_x, coord_y, coord_z,
                    input ready);
    modport sink (input valid, cmd, perm_index, perm_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

// ===== hw/rtl/snd_noise_if.sv =====
interface snd_noise_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink (input valid, noise_value, output ready);
endinterface

// ===== hw/rtl/simplex_noise_2d_3d.sv =====
// simplex noise, 2d and 3d, thirteen register stages
// throughput: one word per cycle; the whole pipeline holds while the output word waits
// load words write the permutation table in order with evaluations, and give no output
// reset clears the valid flags, then a pass over all 256 entries loads the identity into
// every table copy; sample.ready stays low until that pass ends
module simplex_noise_2d_3d (
    input logic          clk,
    input logic          rst_n,
    snd_sample_if.sink   sample,
    snd_noise_if.source  noise
);
    import snd_pkg::*;

    localparam int NCOPY = 5;

    // x mod 12 for an 8-bit value, reciprocal multiply
    function automatic logic [3:0] mod12(input logic [7:0] v);
        logic [18:0] p;
        logic [7:0]  q;
        logic [7:0]  r;
        p = 19'(v) * 19'd171;
        q = 8'(p >> 11);
        r = v - 8'(q * 8'd12);
        return r[3:0];
    endfunction

    function automatic logic signed [33:0] grad_dot(input logic [3:0] gi,
                                                    input logic signed [31:0] dx,
                                                    input logic signed [31:0] dy,
                                                    input logic signed [31:0] dz);
        logic signed [33:0] ex;
        logic signed [33:0] ey;
        logic signed [33:0] ez;
        logic signed [33:0] d;
        ex = 34'(dx);
        ey = 34'(dy);
        ez = 34'(dz);
        unique case (gi)
            4'd0:    d = ex + ey;
            4'd1:    d = ey - ex;
            4'd2:    d = ex - ey;
            4'd3:    d = -ex - ey;
            4'd4:    d = ex + ez;
            4'd5:    d = ez - ex;
            4'd6:    d = ex - ez;
            4'd7:    d = -ex - ez;
            4'd8:    d = ey + ez;
            4'd9:    d = ez - ey;
            4'd10:   d = ey - ez;
            4'd11:   d = -ey - ez;
            default: d = '0;
        endcase
        return d;
    endfunction

    // table fill after reset: one identity entry per cycle into every copy
    logic             init_busy_reg;
    logic [IDX_W-1:0] init_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_addr_reg <= '0;
        end
        else if (init_busy_reg)
        begin
            init_addr_reg <= init_addr_reg + IDX_W'(1);
            if (init_addr_reg == IDX_W'(PERM_SIZE - 1))
                init_busy_reg <= 1'b0;
        end
    end

    // global advance: the pipeline moves when the output register is free or taken
    logic en;
    logic take;
    logic out_valid_reg;
    logic signed [31:0] out_value_reg;
    assign en = !out_valid_reg || noise.ready;
    assign sample.ready = en && !init_busy_reg;
    assign take = sample.valid && sample.ready;
    assign noise.valid = out_valid_reg;
    assign noise.noise_value = out_value_reg;

    logic [12:1] ev_reg;   // evaluation word in stage
    logic [5:1]  ld_reg;   // table load word in stage

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg        <= '0;
            ld_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ev_reg[1] <= take &&
                         (sample.cmd == CMD_EVAL2 || sample.cmd == CMD_EVAL3);
            ld_reg[1] <= take && sample.cmd == CMD_LOAD;
            ev_reg[12:2] <= ev_reg[11:1];
            ld_reg[5:2]  <= ld_reg[4:1];
            out_valid_reg <= ev_reg[12];
        end
    end

    // table copies: copy 0 serves the z level, 1-2 the y level, 3-4 the x level.
    // each level is written when a load word passes its read stage, which keeps
    // table updates ordered against evaluations on either side
    logic [IDX_W-1:0] mem_addr  [NCOPY][2];
    logic [7:0]       mem_rd    [NCOPY][2];
    logic             mem_wen   [NCOPY];
    logic [IDX_W-1:0] mem_waddr [NCOPY];
    logic [7:0]       mem_wdata [NCOPY];

    for (genvar m = 0; m < NCOPY; m++)
    begin : g_copy
        logic [7:0] ram [PERM_SIZE];
        logic [7:0] rd_reg [2];

        always_ff @(posedge clk)
        begin
            if (init_busy_reg)
                ram[init_addr_reg] <= 8'(init_addr_reg);
            else if (en && mem_wen[m])
                ram[mem_waddr[m]] <= mem_wdata[m];
            if (en)
            begin
                for (int p = 0; p < 2; p++)
                begin
                    rd_reg[p] <= ram[mem_addr[m][p]];
                end
            end
        end

        assign mem_rd[m][0] = rd_reg[0];
        assign mem_rd[m][1] = rd_reg[1];
    end

    // stage 1: skew sum
    logic               s1_is3d_reg;
    logic [7:0]         s1_pidx_reg, s1_pval_reg;
    logic signed [47:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic signed [49:0] s1_sum_reg;
    logic               is3d_in;
    logic signed [49:0] sum_next;

    assign is3d_in = sample.cmd == CMD_EVAL3;
    assign sum_next = 50'(sample.coord_x) + 50'(sample.coord_y)
                    + (is3d_in ? 50'(sample.coord_z) : 50'sd0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_is3d_reg <= is3d_in;
            s1_pidx_reg <= sample.perm_index;
            s1_pval_reg <= sample.perm_value;
            s1_x_reg    <= sample.coord_x;
            s1_y_reg    <= sample.coord_y;
            s1_z_reg    <= sample.coord_z;
            s1_sum_reg  <= sum_next;
        end
    end

    // stage 2: skew products, kept mod 2^40 (cell index and fraction only)
    logic        s2_is3d_reg;
    logic [7:0]  s2_pidx_reg, s2_pval_reg;
    logic [39:0] s2_x_reg, s2_y_reg, s2_z_reg;
    logic [47:0] s2_hlo_reg;
    logic [23:0] s2_hhi_reg;
    logic [31:0] s2_lo_reg;

    logic [31:0]                   skew_f;
    logic signed [49:0]            hi_s;
    logic [39:0]                   hi40;
    logic [COORD_FRAC_BITS+31:0]   lo_prod;
    logic [47:0]                   hhi_prod;

    assign skew_f   = s1_is3d_reg ? F3_Q32 : F2_Q32;
    assign hi_s     = s1_sum_reg >>> COORD_FRAC_BITS;
    assign hi40     = hi_s[39:0];
    assign lo_prod  = (COORD_FRAC_BITS + 32)'(s1_sum_reg[COORD_FRAC_BITS-1:0])
                    * (COORD_FRAC_BITS + 32)'(skew_f);
    assign hhi_prod = 48'(hi40[39:16]) * 48'(skew_f[23:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_is3d_reg <= s1_is3d_reg;
            s2_pidx_reg <= s1_pidx_reg;
            s2_pval_reg <= s1_pval_reg;
            s2_x_reg    <= s1_x_reg[39:0];
            s2_y_reg    <= s1_y_reg[39:0];
            s2_z_reg    <= s1_z_reg[39:0];
            s2_hlo_reg  <= 48'(hi40[15:0]) * 48'(skew_f);
            s2_hhi_reg  <= hhi_prod[23:0];
            s2_lo_reg   <= lo_prod[COORD_FRAC_BITS+31:COORD_FRAC_BITS];
        end
    end

    // stage 3: lattice cell and q28 fraction
    logic        s3_is3d_reg;
    logic [7:0]  s3_pidx_reg, s3_pval_reg;
    logic [7:0]  s3_cx_reg, s3_cy_reg, s3_cz_reg;
    logic [27:0] s3_fx_reg, s3_fy_reg, s3_fz_reg;
    logic [39:0] skew_s, wx, wy, wz;

    assign skew_s = s2_hlo_reg[39:0] + {s2_hhi_reg, 16'b0} + {8'b0, s2_lo_reg};
    assign wx = (s2_x_reg << SKEW_SH) + skew_s;
    assign wy = (s2_y_reg << SKEW_SH) + skew_s;
    assign wz = (s2_z_reg << SKEW_SH) + skew_s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_is3d_reg <= s2_is3d_reg;
            s3_pidx_reg <= s2_pidx_reg;
            s3_pval_reg <= s2_pval_reg;
            s3_cx_reg   <= wx[39:32];
            s3_cy_reg   <= wy[39:32];
            s3_cz_reg   <= wz[39:32];
            s3_fx_reg   <= wx[31:4];
            s3_fy_reg   <= wy[31:4];
            s3_fz_reg   <= wz[31:4];
        end
    end

    // stage 4: unskew offset, z level table read
    logic        s4_is3d_reg;
    logic [7:0]  s4_pidx_reg, s4_pval_reg;
    logic [7:0]  s4_cx_reg, s4_cy_reg;
    logic [27:0] s4_fx_reg, s4_fy_reg, s4_fz_reg;
    logic [29:0] s4_g_reg;
    logic [29:0] fsum;
    logic [61:0] gprod;

    assign fsum  = 30'(s3_fx_reg) + 30'(s3_fy_reg) + (s3_is3d_reg ? 30'(s3_fz_reg) : 30'd0);
    assign gprod = 62'(fsum) * 62'(s3_is3d_reg ? G3_Q32 : G2_Q32);

    assign mem_addr[0][0] = s3_cz_reg;
    assign mem_addr[0][1] = s3_cz_reg + 8'd1;
    assign mem_wen[0]     = ld_reg[3];
    assign mem_waddr[0]   = s3_pidx_reg;
    assign mem_wdata[0]   = s3_pval_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_is3d_reg <= s3_is3d_reg;
            s4_pidx_reg <= s3_pidx_reg;
            s4_pval_reg <= s3_pval_reg;
            s4_cx_reg   <= s3_cx_reg;
            s4_cy_reg   <= s3_cy_reg;
            s4_fx_reg   <= s3_fx_reg;
            s4_fy_reg   <= s3_fy_reg;
            s4_fz_reg   <= s3_fz_reg;
            s4_g_reg    <= gprod[61:32];
        end
    end

    // stage 5: corner-0 offsets, y level read for all four (b, c) combinations
    logic               s5_is3d_reg;
    logic [7:0]         s5_pidx_reg, s5_pval_reg;
    logic [7:0]         s5_cx_reg;
    logic signed [31:0] s5_x0_reg, s5_y0_reg, s5_z0_reg;
    logic [7:0]         ylvl_addr [4];

    always_comb
    begin
        for (int bc = 0; bc < 4; bc++)
        begin
            ylvl_addr[bc] = s4_cy_reg + 8'(bc >> 1)
                          + (s4_is3d_reg ? mem_rd[0][bc & 1] : 8'd0);
        end
    end

    assign mem_addr[1][0] = ylvl_addr[0];
    assign mem_addr[1][1] = ylvl_addr[1];
    assign mem_addr[2][0] = ylvl_addr[2];
    assign mem_addr[2][1] = ylvl_addr[3];
    assign mem_wen[1]     = ld_reg[4];
    assign mem_wen[2]     = ld_reg[4];
    assign mem_waddr[1]   = s4_pidx_reg;
    assign mem_waddr[2]   = s4_pidx_reg;
    assign mem_wdata[1]   = s4_pval_reg;
    assign mem_wdata[2]   = s4_pval_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_is3d_reg <= s4_is3d_reg;
            s5_pidx_reg <= s4_pidx_reg;
            s5_pval_reg <= s4_pval_reg;
            s5_cx_reg   <= s4_cx_reg;
            s5_x0_reg   <= $signed({4'b0, s4_fx_reg}) - $signed({2'b0, s4_g_reg});
            s5_y0_reg   <= $signed({4'b0, s4_fy_reg}) - $signed({2'b0, s4_g_reg});
            s5_z0_reg   <= s4_is3d_reg ? $signed({4'b0, s4_fz_reg}) - $signed({2'b0, s4_g_reg})
                                       : 32'sd0;
        end
    end

    // stage 6: simplex corner order, corner offsets, x level read
    logic               s6_is3d_reg;
    logic signed [31:0] s6_dx_reg [4];
    logic signed [31:0] s6_dy_reg [4];
    logic signed [31:0] s6_dz_reg [4];
    logic [3:0]         s6_act_reg;

    logic [2:0]         abc1, abc2;   // {a, b, c} steps of the middle corners
    logic [2:0]         slot_abc [4];
    logic signed [31:0] slot_k [4];
    logic [7:0]         xlvl_addr [4];
    logic signed [31:0] dx_n [4], dy_n [4], dz_n [4];

    always_comb
    begin
        if (s5_is3d_reg)
        begin
            if (s5_x0_reg >= s5_y0_reg)
            begin
                if (s5_y0_reg >= s5_z0_reg)
                begin
                    abc1 = 3'b100;
                    abc2 = 3'b110;
                end
                else if (s5_x0_reg >= s5_z0_reg)
                begin
                    abc1 = 3'b100;
                    abc2 = 3'b101;
                end
                else
                begin
                    abc1 = 3'b001;
                    abc2 = 3'b101;
                end
            end
            else
            begin
                if (s5_y0_reg < s5_z0_reg)
                begin
                    abc1 = 3'b001;
                    abc2 = 3'b011;
                end
                else if (s5_x0_reg < s5_z0_reg)
                begin
                    abc1 = 3'b010;
                    abc2 = 3'b011;
                end
                else
                begin
                    abc1 = 3'b010;
                    abc2 = 3'b110;
                end
            end
        end
        else
        begin
            // 2d tie goes to the y-first corner
            abc1 = (s5_x0_reg > s5_y0_reg) ? 3'b100 : 3'b010;
            abc2 = 3'b110;
        end

        slot_abc[0] = 3'b000;
        slot_abc[1] = abc1;
        slot_abc[2] = abc2;
        slot_abc[3] = s5_is3d_reg ? 3'b111 : 3'b000;
        slot_k[0]   = 32'sd0;
        slot_k[1]   = s5_is3d_reg ? G3_Q28 : G2_Q28;
        slot_k[2]   = s5_is3d_reg ? G3X2_Q28 : G2X2_Q28;
        slot_k[3]   = s5_is3d_reg ? G3X3_Q28 : 32'sd0;

        for (int s = 0; s < 4; s++)
        begin
            xlvl_addr[s] = s5_cx_reg + 8'(slot_abc[s][2])
                         + mem_rd[1 + (slot_abc[s][1] ? 1 : 0)][slot_abc[s][0] ? 1 : 0];
            dx_n[s] = s5_x0_reg - (slot_abc[s][2] ? Q28_ONE : 32'sd0) + slot_k[s];
            dy_n[s] = s5_y0_reg - (slot_abc[s][1] ? Q28_ONE : 32'sd0) + slot_k[s];
            dz_n[s] = s5_is3d_reg
                    ? s5_z0_reg - (slot_abc[s][0] ? Q28_ONE : 32'sd0) + slot_k[s]
                    : 32'sd0;
        end
    end

    assign mem_addr[3][0] = xlvl_addr[0];
    assign mem_addr[3][1] = xlvl_addr[1];
    assign mem_addr[4][0] = xlvl_addr[2];
    assign mem_addr[4][1] = xlvl_addr[3];
    assign mem_wen[3]     = ld_reg[5];
    assign mem_wen[4]     = ld_reg[5];
    assign mem_waddr[3]   = s5_pidx_reg;
    assign mem_waddr[4]   = s5_pidx_reg;
    assign mem_wdata[3]   = s5_pval_reg;
    assign mem_wdata[4]   = s5_pval_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_is3d_reg <= s5_is3d_reg;
            s6_act_reg  <= {s5_is3d_reg, 3'b111};
            for (int s = 0; s < 4; s++)
            begin
                s6_dx_reg[s] <= dx_n[s];
                s6_dy_reg[s] <= dy_n[s];
                s6_dz_reg[s] <= dz_n[s];
            end
        end
    end

    // stage 7: squared distances and gradient dot products
    logic               s7_is3d_reg;
    logic [3:0]         s7_act_reg;
    logic signed [63:0] s7_sqx_reg [4], s7_sqy_reg [4], s7_sqz_reg [4];
    logic signed [33:0] s7_dot_reg [4];
    logic [7:0]         hash_val [4];

    assign hash_val[0] = mem_rd[3][0];
    assign hash_val[1] = mem_rd[3][1];
    assign hash_val[2] = mem_rd[4][0];
    assign hash_val[3] = mem_rd[4][1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_is3d_reg <= s6_is3d_reg;
            s7_act_reg  <= s6_act_reg;
            for (int s = 0; s < 4; s++)
            begin
                s7_sqx_reg[s] <= s6_dx_reg[s] * s6_dx_reg[s];
                s7_sqy_reg[s] <= s6_dy_reg[s] * s6_dy_reg[s];
                s7_sqz_reg[s] <= s6_dz_reg[s] * s6_dz_reg[s];
                s7_dot_reg[s] <= grad_dot(mod12(hash_val[s]), s6_dx_reg[s],
                                          s6_dy_reg[s], s6_dz_reg[s]);
            end
        end
    end

    // stage 8: falloff t, truncated to q28
    logic               s8_is3d_reg;
    logic [3:0]         s8_live_reg;
    logic [27:0]        s8_tq_reg [4];
    logic signed [33:0] s8_dot_reg [4];
    logic signed [63:0] t_n [4];

    always_comb
    begin
        for (int s = 0; s < 4; s++)
        begin
            t_n[s] = (s7_is3d_reg ? LIM3_Q56 : LIM2_Q56)
                   - (s7_sqx_reg[s] + s7_sqy_reg[s] + s7_sqz_reg[s]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_is3d_reg <= s7_is3d_reg;
            for (int s = 0; s < 4; s++)
            begin
                s8_live_reg[s] <= s7_act_reg[s] && !t_n[s][63];
                s8_tq_reg[s]   <= t_n[s][55:28];
                s8_dot_reg[s]  <= s7_dot_reg[s];
            end
        end
    end

    // stages 9 and 10: t^2 then t^4
    logic               s9_is3d_reg, s10_is3d_reg;
    logic [3:0]         s9_live_reg, s10_live_reg;
    logic [27:0]        s9_t2_reg [4], s10_t4_reg [4];
    logic signed [33:0] s9_dot_reg [4], s10_dot_reg [4];
    logic [55:0]        sq9 [4], sq10 [4];

    always_comb
    begin
        for (int s = 0; s < 4; s++)
        begin
            sq9[s]  = 56'(s8_tq_reg[s]) * 56'(s8_tq_reg[s]);
            sq10[s] = 56'(s9_t2_reg[s]) * 56'(s9_t2_reg[s]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_is3d_reg  <= s8_is3d_reg;
            s9_live_reg  <= s8_live_reg;
            s10_is3d_reg <= s9_is3d_reg;
            s10_live_reg <= s9_live_reg;
            for (int s = 0; s < 4; s++)
            begin
                s9_t2_reg[s]   <= sq9[s][55:28];
                s9_dot_reg[s]  <= s8_dot_reg[s];
                s10_t4_reg[s]  <= sq10[s][55:28];
                s10_dot_reg[s] <= s9_dot_reg[s];
            end
        end
    end

    // stage 11: corner contributions, floored to q30
    logic               s11_is3d_reg;
    logic signed [39:0] s11_term_reg [4];
    logic signed [62:0] cprod [4];

    always_comb
    begin
        for (int s = 0; s < 4; s++)
            cprod[s] = $signed({1'b0, s10_t4_reg[s]}) * s10_dot_reg[s];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_is3d_reg <= s10_is3d_reg;
            for (int s = 0; s < 4; s++)
            begin
                s11_term_reg[s] <= s10_live_reg[s] ? 40'(cprod[s] >>> 26) : 40'sd0;
            end
        end
    end

    // stage 12: corner sum
    logic               s12_is3d_reg;
    logic signed [41:0] s12_sum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s12_is3d_reg <= s11_is3d_reg;
            s12_sum_reg  <= 42'(s11_term_reg[0]) + 42'(s11_term_reg[1])
                          + 42'(s11_term_reg[2]) + 42'(s11_term_reg[3]);
        end
    end

    // stage 13: scale by 32 or 70 and saturate into the output register
    logic signed [47:0] sum48, scaled;
    logic signed [31:0] sat;

    assign sum48  = 48'(s12_sum_reg);
    assign scaled = s12_is3d_reg ? (sum48 <<< 5)
                                 : (sum48 <<< 6) + (sum48 <<< 2) + (sum48 <<< 1);

    always_comb
    begin
        priority if (scaled > OUT_ONE)
            sat = 32'(OUT_ONE);
        else if (scaled < -OUT_ONE)
            sat = 32'(-OUT_ONE);
        else
            sat = 32'(scaled);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_value_reg <= sat;
    end

endmodule
